// ===== rtl/rxcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the run-XOR chunk de-obfuscator.
// No dependencies; every other file in rtl/ imports this package.
package rxcd_pkg;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

  // Error codes, reported only on the final word of a chunk.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEN   = 2'd1,
    ERR_PLACE = 2'd2
  } err_t;

  localparam logic [7:0] VERSION_MIN  = 8'h1B;
  localparam logic [7:0] KEY_FLIP     = 8'hFF;
  localparam logic [7:0] NAME_XOR     = 8'h55;
  localparam logic [6:0] NAME_BYTES   = 7'd16;
  localparam logic [6:0] STRIDE_LONG  = 7'h64;
  localparam logic [6:0] STRIDE_SHORT = 7'h54;
  localparam logic [31:0] REC_BASE    = 32'd32;

  // End of the last name field is count*stride + REC_BASE + NAME_BYTES - stride.
  localparam logic [31:0] LIM_ADJ_LONG  = 32'd52;  // 100 - 48
  localparam logic [31:0] LIM_ADJ_SHORT = 32'd36;  // 84 - 48

  // One processed chunk byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    err_t       err;
  } res_t;

  // Key table read request from the core.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } key_rd_t;

endpackage

// ===== rtl/rxcd_keymem.sv =====
`timescale 1ns / 1ps
// 256 x 8 key table: one write port, one read port with registered data.
// Depends on rxcd_pkg for the read request struct.
module rxcd_keymem (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [7:0]       wr_addr,
  input  logic [7:0]       wr_data,
  input  rxcd_pkg::key_rd_t rd_req,
  output logic [7:0]       rd_data
);
  import rxcd_pkg::*;

  logic [7:0] mem [256];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so the key stays put across idle gaps.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rxcd_core.sv =====
`timescale 1ns / 1ps
// Per-chunk state and the single-pass byte transform (run inversion, name xor).
// Depends on rxcd_pkg; reads the key table through rxcd_keymem.
module rxcd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_go,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic [7:0]         key_rd,
  output rxcd_pkg::key_rd_t  key_req,
  output rxcd_pkg::res_t     res
);
  import rxcd_pkg::*;

  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [23:0] dl_r, dl_nxt;
  logic [23:0] rc_r, rc_nxt;
  logic [31:0] tew_r, tew_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] step_r, step_nxt;
  logic [4:0]  rr_r, rr_nxt;
  logic        inv_r, inv_nxt;
  logic        short_r, short_nxt;
  logic [6:0]  ro_r, ro_nxt;
  logic [23:0] rn_r, rn_nxt;

  logic        enc;
  logic [31:0] key_eff;
  logic        run_start;
  logic [4:0]  run_len;
  logic [32:0] run_end;
  logic [4:0]  rr_eff;
  logic        inv_eff;
  logic [7:0]  b1, b2;
  logic [31:0] prod84, prod100, lim;
  logic [6:0]  stride;
  logic [6:0]  ro_inc;
  logic [32:0] size;
  err_t        err;

  // The start key was read from the table on the byte at position 7.
  assign key_eff = (pos_r == 32'd8) ? {24'd0, key_rd} : key_r;
  assign key_req.en   = byte_go && (pos_r == 32'd7);
  assign key_req.addr = data_byte ^ KEY_FLIP;

  assign prod84  = {8'd0, rc_r} * 32'd84;
  assign prod100 = {8'd0, rc_r} * 32'd100;

  always_comb begin
    ver_nxt   = ver_r;
    dl_nxt    = dl_r;
    rc_nxt    = rc_r;
    tew_nxt   = tew_r;
    key_nxt   = key_r;
    step_nxt  = step_r;
    rr_nxt    = rr_r;
    inv_nxt   = inv_r;
    short_nxt = short_r;
    ro_nxt    = ro_r;
    rn_nxt    = rn_r;
    run_start = 1'b0;
    run_len   = {2'b10, key_eff[6:4]};
    run_end   = {1'b0, pos_r} + {28'd0, run_len};
    rr_eff    = rr_r;
    inv_eff   = inv_r;
    b1        = data_byte;
    stride    = short_r ? STRIDE_SHORT : STRIDE_LONG;
    ro_inc    = ro_r + 7'd1;
    size      = {1'b0, pos_r} + 33'd1;
    lim       = 32'd0;
    err       = ERR_NONE;

    // Header fields, little-endian.
    case (pos_r)
      32'd0: dl_nxt[7:0]   = data_byte;
      32'd1: dl_nxt[15:8]  = data_byte;
      32'd2: dl_nxt[23:16] = data_byte;
      32'd3: ver_nxt       = data_byte;
      32'd4: rc_nxt[7:0]   = data_byte;
      32'd5: rc_nxt[15:8]  = data_byte;
      32'd6: rc_nxt[23:16] = data_byte;
      default: ;
    endcase
    enc = (pos_r >= 32'd3) && (ver_nxt >= VERSION_MIN);

    if (enc && pos_r >= 32'd8) begin
      run_start = (rr_r == 5'd0) && (pos_r < {8'd0, dl_r});
      if (run_start) begin
        step_nxt = step_r + 32'd1;
        key_nxt  = key_eff + step_nxt;
        rr_eff   = run_len;
        inv_eff  = key_eff[0] && (run_end < {9'd0, dl_r});
        inv_nxt  = inv_eff;
      end
      if (rr_eff != 5'd0) begin
        if (inv_eff) begin
          b1 = ~data_byte;
        end
        rr_nxt = rr_eff - 5'd1;
      end
    end

    // Table end word is taken after inversion; it picks the record stride.
    if (pos_r >= 32'd20 && pos_r < 32'd24) begin
      case (pos_r[1:0])
        2'd0: tew_nxt[7:0]   = b1;
        2'd1: tew_nxt[15:8]  = b1;
        2'd2: tew_nxt[23:16] = b1;
        default: tew_nxt[31:24] = b1;
      endcase
      if (pos_r == 32'd23) begin
        short_nxt = (rc_r != 24'd0) && ((REC_BASE + prod84) == tew_nxt);
      end
    end

    b2 = b1;
    if (enc && pos_r >= REC_BASE && rn_r < rc_r) begin
      if (ro_r < NAME_BYTES) begin
        b2 = b1 ^ NAME_XOR;
      end
      if (ro_inc >= stride) begin
        ro_nxt = 7'd0;
        rn_nxt = rn_r + 24'd1;
      end else begin
        ro_nxt = ro_inc;
      end
    end

    lim = short_nxt ? (prod84 - LIM_ADJ_SHORT) : (prod100 - LIM_ADJ_LONG);
    if (last && enc && size >= 33'd8) begin
      if ({9'd0, dl_r} > size) begin
        err = ERR_LEN;
      end else if (rc_r != 24'd0 && {1'b0, lim} > size) begin
        err = ERR_PLACE;
      end
    end

    pos_nxt = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
  end

  assign res.data = b2;
  assign res.last = last;
  assign res.err  = err;

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_go && last)) begin
      pos_r   <= '0;
      ver_r   <= '0;
      dl_r    <= '0;
      rc_r    <= '0;
      tew_r   <= '0;
      key_r   <= '0;
      step_r  <= '0;
      rr_r    <= '0;
      inv_r   <= 1'b0;
      short_r <= 1'b0;
      ro_r    <= '0;
      rn_r    <= '0;
    end else if (byte_go) begin
      pos_r   <= pos_nxt;
      ver_r   <= ver_nxt;
      dl_r    <= dl_nxt;
      rc_r    <= rc_nxt;
      tew_r   <= tew_nxt;
      key_r   <= key_nxt;
      step_r  <= step_nxt;
      rr_r    <= rr_nxt;
      inv_r   <= inv_nxt;
      short_r <= short_nxt;
      ro_r    <= ro_nxt;
      rn_r    <= rn_nxt;
    end
  end

endmodule

// ===== rtl/run_xor_chunk_deobfuscator.sv =====
`timescale 1ns / 1ps
// Top level of the run-XOR chunk de-obfuscator: stream ports and result register.
// Depends on rxcd_pkg, rxcd_keymem and rxcd_core.
//
//  channel | direction | carries
//  in_*    | slave     | key table loads and chunk bytes, one word per cycle
//  out_*   | master    | one processed byte per chunk byte word
//
// The transform sits between the chunk state registers and the output register.
// One word is accepted every cycle while the output register is empty or being
// drained; load words never produce output.
// The key table read at byte 7 is registered and used from byte 8 on.
// rst_n clears the chunk state and the output valid; the key table is not cleared.
module run_xor_chunk_deobfuscator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // table_index[7:0], table_value[15:8], data_byte[23:16]
  input  logic        in_tuser,  // operation: 0 key load, 1 chunk byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // out_byte[7:0], error_code[9:8], zeros above
  output logic        out_tlast
);
  import rxcd_pkg::*;

  logic    accept;
  logic    byte_go;
  logic    load_go;
  logic [7:0] key_rd;
  key_rd_t key_req;
  res_t    res;
  res_t    res_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign byte_go   = accept && (op_t'(in_tuser) == OP_BYTE);
  assign load_go   = accept && (op_t'(in_tuser) == OP_LOAD);

  rxcd_keymem u_keymem (
    .clk     (clk),
    .wr_en   (load_go),
    .wr_addr (in_tdata[7:0]),
    .wr_data (in_tdata[15:8]),
    .rd_req  (key_req),
    .rd_data (key_rd)
  );

  rxcd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_go   (byte_go),
    .data_byte (in_tdata[23:16]),
    .last      (in_tlast),
    .key_rd    (key_rd),
    .key_req   (key_req),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (byte_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.err, res_r.data};
  assign out_tlast  = res_r.last;

endmodule
